// File: rtl/websocket_frame_parser_macros.svh
// Assertion helpers for the frame parser.
`ifndef WEBSOCKET_FRAME_PARSER_MACROS_SVH
`define WEBSOCKET_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WSFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wsfp_pkg.sv
`timescale 1ns / 1ps

package wsfp_pkg;

    localparam int LENGTH_WIDTH = 32;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_MASKLEN = 3'd1;
    localparam logic [2:0] PH_LEN16   = 3'd2;
    localparam logic [2:0] PH_LEN64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNMASKED = 2'd1;
    localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] HDR_BYTES_LEN16 = 4'd2;
    localparam logic [3:0] HDR_BYTES_LEN64 = 4'd8;
    localparam logic [3:0] HDR_BYTES_KEY   = 4'd4;

    typedef struct packed {
        logic       op;
        logic [7:0] byte_in;
    } t_item;

    typedef struct packed {
        logic        accepted;
        logic        header_done;
        logic        fin;
        logic [2:0]  rsv_bits;
        logic [3:0]  opcode_out;
        logic [31:0] frame_length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [1:0]  error_kind;
    } t_result;

endpackage

// File: rtl/wsfp_if.sv
`timescale 1ns / 1ps

interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] byte_in;

    modport source (output valid, output op, output byte_in, input ready);
    modport sink   (input valid, input op, input byte_in, output ready);
endinterface

interface wsfp_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        header_done;
    logic        fin;
    logic [2:0]  rsv_bits;
    logic [3:0]  opcode_out;
    logic [31:0] frame_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [1:0]  error_kind;

    modport source (
        output valid, output accepted, output header_done, output fin,
        output rsv_bits, output opcode_out, output frame_length,
        output payload_valid, output payload_byte, output frame_end,
        output error_kind, input ready
    );
    modport sink (
        input valid, input accepted, input header_done, input fin,
        input rsv_bits, input opcode_out, input frame_length,
        input payload_valid, input payload_byte, input frame_end,
        input error_kind, output ready
    );
endinterface

interface wsfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/websocket_frame_parser.sv
`timescale 1ns / 1ps
// WebSocket client-to-server frame parser. Takes one frame byte per transaction
// and returns one result per transaction: header fields, unmasked payload bytes,
// frame end and a sticky error code. Sustains one byte per clock cycle while the
// result sink is ready. Each byte passes through the input register, then the
// parser's per-byte state update into the result register. A stalled result
// keeps the next byte in the input register, and the input stalls once that
// register is full. The user must write max_payload through the config channel
// only while idle; the block itself does not enforce this.

module websocket_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfp_in_if.sink     i_in,
    wsfp_out_if.source  o_out,
    wsfp_cfg_if.sink    i_cfg
);
    import wsfp_pkg::*;

    `include "websocket_frame_parser_macros.svh"

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_out_valid;
    t_result     r_out;
    logic [31:0] r_max_payload;

    t_result     n_result;
    logic        s1_adv;
    logic        in_acc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    wsfp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (s1_adv),
        .i_item        (r_s1_item),
        .i_max_payload (r_max_payload),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_max_payload <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item.op      <= i_in.op;
            r_s1_item.byte_in <= i_in.byte_in;
        end
        if (s1_adv) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out.accepted;
    assign o_out.header_done   = r_out.header_done;
    assign o_out.fin           = r_out.fin;
    assign o_out.rsv_bits      = r_out.rsv_bits;
    assign o_out.opcode_out    = r_out.opcode_out;
    assign o_out.frame_length  = r_out.frame_length;
    assign o_out.payload_valid = r_out.payload_valid;
    assign o_out.payload_byte  = r_out.payload_byte;
    assign o_out.frame_end     = r_out.frame_end;
    assign o_out.error_kind    = r_out.error_kind;

    `WSFP_ASSERT_SAME(a_pvalid_accepted, r_out_valid && r_out.payload_valid, r_out.accepted && r_out.error_kind == ERR_NONE, "payload byte from a refused or failed transaction")
    `WSFP_ASSERT_SAME(a_hdone_pvalid_excl, r_out_valid && r_out.header_done, !r_out.payload_valid, "header end and payload byte in one result")
    `WSFP_ASSERT_SAME(a_fend_source, r_out_valid && r_out.frame_end, r_out.header_done || r_out.payload_valid, "frame end without header end or payload byte")
    `WSFP_ASSERT_NEXT(a_result_held, r_out_valid && !o_out.ready, r_out_valid && $stable(r_out), "stalled result register changed")

endmodule

// File: rtl/wsfp_parse.sv
`timescale 1ns / 1ps

module wsfp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  wsfp_pkg::t_item   i_item,
    input  logic [31:0]       i_max_payload,
    output wsfp_pkg::t_result o_result
);
    import wsfp_pkg::*;

    logic [2:0]  r_phase,        n_phase;
    logic [3:0]  r_bytes_left,   n_bytes_left;
    logic [63:0] r_len_accum,    n_len_accum;
    logic [31:0] r_remaining,    n_remaining;
    logic [31:0] r_mask_key,     n_mask_key;
    logic [1:0]  r_key_index,    n_key_index;
    logic [7:0]  r_header_bits,  n_header_bits;
    logic [31:0] r_payload_size, n_payload_size;
    logic [1:0]  r_err,          n_err;

    logic [63:0] len_shift;
    logic [63:0] len_cand;
    logic        too_big;
    logic        last_len_byte;
    logic [7:0]  key_byte;
    logic        accepted;
    logic        hdone;
    logic        pvalid;
    logic [7:0]  pbyte;
    logic        fend;

    assign len_shift     = {r_len_accum[55:0], i_item.byte_in};
    assign last_len_byte = (r_bytes_left == 4'd1);
    assign len_cand      = (r_phase == PH_MASKLEN) ? {57'd0, i_item.byte_in[6:0]} : len_shift;
    assign too_big       = (len_cand[63:32] != 32'd0) || (len_cand[31:0] > i_max_payload)
                           || ((len_cand >> LENGTH_WIDTH) != 64'd0);

    always_comb begin
        unique case (r_key_index)
            2'd0: key_byte = r_mask_key[31:24];
            2'd1: key_byte = r_mask_key[23:16];
            2'd2: key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_bytes_left   = r_bytes_left;
        n_len_accum    = r_len_accum;
        n_remaining    = r_remaining;
        n_mask_key     = r_mask_key;
        n_key_index    = r_key_index;
        n_header_bits  = r_header_bits;
        n_payload_size = r_payload_size;
        n_err          = r_err;
        accepted       = 1'b0;
        hdone          = 1'b0;
        pvalid         = 1'b0;
        pbyte          = 8'd0;
        fend           = 1'b0;

        if (i_item.op == OP_RESTART) begin
            n_phase        = PH_FIRST;
            n_bytes_left   = 4'd1;
            n_len_accum    = 64'd0;
            n_remaining    = 32'd0;
            n_mask_key     = 32'd0;
            n_key_index    = 2'd0;
            n_header_bits  = 8'd0;
            n_payload_size = 32'd0;
            n_err          = ERR_NONE;
        end else if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
            accepted = 1'b1;
            unique case (r_phase)
                PH_FIRST: begin
                    n_header_bits = i_item.byte_in;
                    n_phase       = PH_MASKLEN;
                end
                PH_MASKLEN: begin
                    if (!i_item.byte_in[7]) begin
                        n_err   = ERR_UNMASKED;
                        n_phase = PH_ERROR;
                    end else if (i_item.byte_in[6:0] == LEN_EXT16) begin
                        n_phase      = PH_LEN16;
                        n_bytes_left = HDR_BYTES_LEN16;
                        n_len_accum  = 64'd0;
                    end else if (i_item.byte_in[6:0] == LEN_EXT64) begin
                        n_phase      = PH_LEN64;
                        n_bytes_left = HDR_BYTES_LEN64;
                        n_len_accum  = 64'd0;
                    end else if (too_big) begin
                        n_err   = ERR_TOO_BIG;
                        n_phase = PH_ERROR;
                    end else begin
                        n_payload_size = len_cand[31:0];
                        n_phase        = PH_KEY;
                        n_bytes_left   = HDR_BYTES_KEY;
                    end
                end
                PH_LEN16, PH_LEN64: begin
                    n_len_accum  = len_shift;
                    n_bytes_left = r_bytes_left - 4'd1;
                    if (last_len_byte) begin
                        if (too_big) begin
                            n_err   = ERR_TOO_BIG;
                            n_phase = PH_ERROR;
                        end else begin
                            n_payload_size = len_cand[31:0];
                            n_phase        = PH_KEY;
                            n_bytes_left   = HDR_BYTES_KEY;
                        end
                    end
                end
                PH_KEY: begin
                    n_mask_key   = {r_mask_key[23:0], i_item.byte_in};
                    n_bytes_left = r_bytes_left - 4'd1;
                    if (last_len_byte) begin
                        hdone       = 1'b1;
                        n_key_index = 2'd0;
                        n_remaining = r_payload_size;
                        if (r_payload_size == 32'd0) begin
                            fend    = 1'b1;
                            n_phase = PH_DONE;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    pvalid      = 1'b1;
                    pbyte       = i_item.byte_in ^ key_byte;
                    n_key_index = r_key_index + 2'd1;
                    n_remaining = r_remaining - 32'd1;
                    if (r_remaining == 32'd1) begin
                        fend    = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            endcase
        end

        o_result.accepted      = accepted;
        o_result.header_done   = hdone;
        o_result.fin           = n_header_bits[7];
        o_result.rsv_bits      = n_header_bits[6:4];
        o_result.opcode_out    = n_header_bits[3:0];
        o_result.frame_length  = n_payload_size;
        o_result.payload_valid = pvalid;
        o_result.payload_byte  = pbyte;
        o_result.frame_end     = fend;
        o_result.error_kind    = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FIRST;
            r_bytes_left   <= 4'd1;
            r_len_accum    <= 64'd0;
            r_remaining    <= 32'd0;
            r_mask_key     <= 32'd0;
            r_key_index    <= 2'd0;
            r_header_bits  <= 8'd0;
            r_payload_size <= 32'd0;
            r_err          <= ERR_NONE;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_len_accum    <= n_len_accum;
            r_remaining    <= n_remaining;
            r_mask_key     <= n_mask_key;
            r_key_index    <= n_key_index;
            r_header_bits  <= n_header_bits;
            r_payload_size <= n_payload_size;
            r_err          <= n_err;
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import wsfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 85;

    localparam logic [8:0] OPENING_SEQ [0:28] = '{
        // complete frame: one payload byte
        {OP_DATA, 8'hFF}, {OP_DATA, 8'h81},
        {OP_DATA, 8'h00}, {OP_DATA, 8'hFF}, {OP_DATA, 8'hA5}, {OP_DATA, 8'h5A},
        {OP_DATA, 8'hC3}, {OP_RESTART, 8'hFF},
        // mask bit clear with 64-bit length code, then a refused byte
        {OP_DATA, 8'h0F}, {OP_DATA, 8'h7F}, {OP_DATA, 8'hFF}, {OP_RESTART, 8'h00},
        // empty payload ends at the last key byte
        {OP_DATA, 8'h80}, {OP_DATA, 8'h80},
        {OP_DATA, 8'hFF}, {OP_DATA, 8'hFF}, {OP_DATA, 8'hFF}, {OP_DATA, 8'hFF},
        {OP_RESTART, 8'h5A},
        // 64-bit length of 2^32 does not fit
        {OP_DATA, 8'h70}, {OP_DATA, 8'hFF},
        {OP_DATA, 8'h00}, {OP_DATA, 8'h00}, {OP_DATA, 8'h00}, {OP_DATA, 8'h01},
        {OP_DATA, 8'h00}, {OP_DATA, 8'h00}, {OP_DATA, 8'h00}, {OP_DATA, 8'h00}
    };

    class frame_scoreboard;
        logic [31:0] max_len;
        logic [2:0]  phase;
        logic [3:0]  bytes_left;
        logic [63:0] len_acc;
        logic [31:0] remaining;
        logic [31:0] key;
        logic [1:0]  key_idx;
        logic [7:0]  hdr;
        logic [31:0] size;
        logic [1:0]  err;
        t_result     pending_results [$];
        int unsigned failures;
        int unsigned n_checked;
        int unsigned n_payload;
        int unsigned n_headers;
        int unsigned n_ends;
        int unsigned n_unmasked;
        int unsigned n_too_big;

        function new();
            max_len = MAX_PAYLOAD_RESET;
            clear_frame();
            failures = 0;
            n_checked = 0;
            n_payload = 0;
            n_headers = 0;
            n_ends = 0;
            n_unmasked = 0;
            n_too_big = 0;
        endfunction

        function void clear_frame();
            phase = PH_FIRST;
            bytes_left = 4'd1;
            len_acc = '0;
            remaining = '0;
            key = '0;
            key_idx = '0;
            hdr = '0;
            size = '0;
            err = ERR_NONE;
        endfunction

        function void set_limit(logic [31:0] v);
            max_len = v;
        endfunction

        function void take_length(logic [63:0] len);
            if (len > {32'd0, max_len} || len > ((64'd1 << LENGTH_WIDTH) - 64'd1)) begin
                err = ERR_TOO_BIG;
                phase = PH_ERROR;
            end else begin
                size = len[31:0];
                phase = PH_KEY;
                bytes_left = HDR_BYTES_KEY;
            end
        endfunction

        // queues the expected result of one input transaction
        function void parse_byte(t_item it);
            t_result r;
            r = '0;
            if (it.op == OP_RESTART) begin
                clear_frame();
                pending_results = {pending_results, r};
                return;
            end
            if (phase != PH_DONE && phase != PH_ERROR) begin
                r.accepted = 1'b1;
                case (phase)
                    PH_FIRST: begin
                        hdr = it.byte_in;
                        phase = PH_MASKLEN;
                    end
                    PH_MASKLEN: begin
                        if (!it.byte_in[7]) begin
                            err = ERR_UNMASKED;
                            phase = PH_ERROR;
                        end else if (it.byte_in[6:0] < LEN_EXT16) begin
                            take_length({57'd0, it.byte_in[6:0]});
                        end else if (it.byte_in[6:0] == LEN_EXT16) begin
                            phase = PH_LEN16;
                            bytes_left = HDR_BYTES_LEN16;
                            len_acc = '0;
                        end else begin
                            phase = PH_LEN64;
                            bytes_left = HDR_BYTES_LEN64;
                            len_acc = '0;
                        end
                    end
                    PH_LEN16, PH_LEN64: begin
                        len_acc = {len_acc[55:0], it.byte_in};
                        bytes_left = bytes_left - 4'd1;
                        if (bytes_left == 4'd0)
                            take_length(len_acc);
                    end
                    PH_KEY: begin
                        key = {key[23:0], it.byte_in};
                        bytes_left = bytes_left - 4'd1;
                        if (bytes_left == 4'd0) begin
                            r.header_done = 1'b1;
                            key_idx = '0;
                            remaining = size;
                            if (size == 32'd0) begin
                                r.frame_end = 1'b1;
                                phase = PH_DONE;
                            end else begin
                                phase = PH_PAYLOAD;
                            end
                        end
                    end
                    default: begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = it.byte_in ^ key[8 * (3 - int'(key_idx)) +: 8];
                        key_idx = key_idx + 2'd1;
                        remaining = remaining - 32'd1;
                        if (remaining == 32'd0) begin
                            r.frame_end = 1'b1;
                            phase = PH_DONE;
                        end
                    end
                endcase
            end
            r.fin = hdr[7];
            r.rsv_bits = hdr[6:4];
            r.opcode_out = hdr[3:0];
            r.frame_length = size;
            r.error_kind = err;
            pending_results = {pending_results, r};
        endfunction

        function void field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            field_ok("accepted", 32'(want.accepted), 32'(got.accepted));
            field_ok("header_done", 32'(want.header_done), 32'(got.header_done));
            field_ok("fin", 32'(want.fin), 32'(got.fin));
            field_ok("rsv_bits", 32'(want.rsv_bits), 32'(got.rsv_bits));
            field_ok("opcode_out", 32'(want.opcode_out), 32'(got.opcode_out));
            field_ok("frame_length", want.frame_length, got.frame_length);
            field_ok("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
            field_ok("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            field_ok("frame_end", 32'(want.frame_end), 32'(got.frame_end));
            field_ok("error_kind", 32'(want.error_kind), 32'(got.error_kind));
            if (want.payload_valid)
                n_payload++;
            if (want.header_done)
                n_headers++;
            if (want.frame_end)
                n_ends++;
            if (want.accepted && want.error_kind == ERR_UNMASKED)
                n_unmasked++;
            if (want.accepted && want.error_kind == ERR_TOO_BIG)
                n_too_big++;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int unsigned counted;
    int unsigned cycle_count;
    t_result     observed;

    frame_scoreboard sb = new();

    wsfp_in_if  in_if ();
    wsfp_out_if out_if ();
    wsfp_cfg_if cfg_if ();

    websocket_frame_parser uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_if.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            observed.accepted = out_if.accepted;
            observed.header_done = out_if.header_done;
            observed.fin = out_if.fin;
            observed.rsv_bits = out_if.rsv_bits;
            observed.opcode_out = out_if.opcode_out;
            observed.frame_length = out_if.frame_length;
            observed.payload_valid = out_if.payload_valid;
            observed.payload_byte = out_if.payload_byte;
            observed.frame_end = out_if.frame_end;
            observed.error_kind = out_if.error_kind;
            sb.check_result(observed);
        end
    end

    // entered and left at a falling edge
    task automatic push_item(input logic op, input logic [7:0] b);
        t_item it;
        it.op = op;
        it.byte_in = b;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.byte_in <= b;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        sb.parse_byte(it);
        counted++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_limit(v);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_frame();
        int          kind;
        int          pick;
        int          enc;
        int          cap;
        int          n;
        logic [63:0] len;
        push_item(OP_RESTART, 8'($urandom));
        kind = $urandom_range(99);
        if (kind < 70) begin
            pick = $urandom_range(9);
            if (pick < 6)
                len = 64'($urandom_range(0, 12));
            else if (pick < 8)
                len = 64'($urandom_range(0, 300));
            else if (pick == 8)
                len = {32'd0, $urandom};
            else
                len = {$urandom, $urandom};
            if (len < 64'd126)
                enc = $urandom_range(0, 2);
            else if (len < 64'd65536)
                enc = $urandom_range(1, 2);
            else
                enc = 2;
            push_item(OP_DATA, 8'($urandom));
            case (enc)
                0: push_item(OP_DATA, {1'b1, len[6:0]});
                1: begin
                    push_item(OP_DATA, {1'b1, LEN_EXT16});
                    push_item(OP_DATA, len[15:8]);
                    push_item(OP_DATA, len[7:0]);
                end
                default: begin
                    push_item(OP_DATA, {1'b1, LEN_EXT64});
                    for (int i = 7; i >= 0; i--)
                        push_item(OP_DATA, len[8 * i +: 8]);
                end
            endcase
            repeat (4) push_item(OP_DATA, 8'($urandom));
            cap = $urandom_range(0, 24);
            n = (len < 64'(cap)) ? int'(len) : cap;
            repeat (n) push_item(OP_DATA, 8'($urandom));
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 2)) push_item(OP_DATA, 8'($urandom));
        end else if (kind < 85) begin
            push_item(OP_DATA, 8'($urandom));
            push_item(OP_DATA, {1'b0, 7'($urandom)});
            repeat ($urandom_range(0, 3)) push_item(OP_DATA, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 10))
                push_item(($urandom_range(9) == 0) ? OP_RESTART : OP_DATA, 8'($urandom));
        end
        if ($urandom_range(29) == 0)
            wait_drained();
    endtask

    initial begin
        logic [31:0] limits [0:5];
        limits[0] = 32'hFFFF_FFFF;
        limits[1] = 32'd0;
        limits[2] = 32'd24;
        limits[3] = 32'd1;
        limits[4] = 32'($urandom_range(2, 300));
        limits[5] = 32'd65536;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_DATA;
        in_if.byte_in = 8'd0;
        cfg_if.valid = 1'b0;
        cfg_if.data = 32'd0;
        out_if.ready = 1'b0;
        tx_idle_pct = 19;
        rx_idle_pct = 64;
        counted = 0;
        cycle_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (OPENING_SEQ[i])
            push_item(OPENING_SEQ[i][8], OPENING_SEQ[i][7:0]);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            case (p / 2)
                0: begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 64;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 19;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            write_limit(limits[p]);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
                send_frame();
            wait_drained();
        end

        $display("checked %0d transactions: %0d headers, %0d payload bytes, %0d frame ends",
                 sb.n_checked, sb.n_headers, sb.n_payload, sb.n_ends);
        $display("error results: %0d unmasked, %0d oversize, over six max_payload values",
                 sb.n_unmasked, sb.n_too_big);
        if (sb.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.failures);
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/wsfp_pkg.sv
rtl/wsfp_if.sv
rtl/wsfp_parse.sv
rtl/websocket_frame_parser.sv
dv/tb.sv
